>>> hdl/fpac_pkg.sv
package fpac_pkg;

    // Build-time defaults
    localparam int FRAME_BYTES_DEF     = 16384;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int ADDR_W              = 18;   // covers frame word address and palette entry
    localparam int QUEUE_DEPTH         = 2;

    // Actions
    localparam logic [1:0] ACT_READ      = 2'd0;
    localparam logic [1:0] ACT_WRITE     = 2'd1;
    localparam logic [1:0] ACT_PAL_WRITE = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    // Pixel formats
    localparam logic [3:0] FMT_PAL1     = 4'd0;
    localparam logic [3:0] FMT_PAL2     = 4'd1;
    localparam logic [3:0] FMT_PAL4     = 4'd2;
    localparam logic [3:0] FMT_PAL8     = 4'd3;
    localparam logic [3:0] FMT_PAL16    = 4'd4;
    localparam logic [3:0] FMT_GREY1    = 4'd5;
    localparam logic [3:0] FMT_GREY2    = 4'd6;
    localparam logic [3:0] FMT_GREY4    = 4'd7;
    localparam logic [3:0] FMT_GREY8    = 4'd8;
    localparam logic [3:0] FMT_RGB332   = 4'd9;
    localparam logic [3:0] FMT_RGB565   = 4'd10;
    localparam logic [3:0] FMT_ARGB1111 = 4'd11;
    localparam logic [3:0] FMT_ARGB2222 = 4'd12;
    localparam logic [3:0] FMT_ARGB4444 = 4'd13;
    localparam logic [3:0] FMT_ARGB8888 = 4'd14;

    // Register indexes
    localparam logic [1:0] REG_FORMAT    = 2'd0;
    localparam logic [1:0] REG_SWAP      = 2'd1;
    localparam logic [1:0] REG_PAL_COUNT = 2'd2;

    localparam logic [3:0] FORMAT_RST    = FMT_ARGB8888;
    localparam logic [9:0] GREY1_LIMIT   = 10'd384;      // 128*3
    localparam logic [9:0] DIV3_RECIP    = 10'd683;      // 2^11 / 3, exact below 768

    typedef struct packed {
        logic [3:0] fmt;
        logic       swap;
        logic [8:0] pal_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        action;
        logic              oor;
        logic [ADDR_W-1:0] addr;
        logic [4:0]        off;
        logic [2:0]        lg;
        logic [31:0]       mask;
        logic [31:0]       wval;
        logic [31:0]       raw;
    } q_entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FRAME,
        B_PAL
    } back_state_t;

    // log2 of bits per pixel
    function automatic logic [2:0] fmt_lg(input logic [3:0] fmt);
        logic [2:0] r;
        unique case (fmt)
            FMT_PAL1, FMT_GREY1:                              r = 3'd0;
            FMT_PAL2, FMT_GREY2:                              r = 3'd1;
            FMT_PAL4, FMT_GREY4, FMT_ARGB1111:                r = 3'd2;
            FMT_PAL8, FMT_GREY8, FMT_RGB332, FMT_ARGB2222:    r = 3'd3;
            FMT_PAL16, FMT_RGB565, FMT_ARGB4444:              r = 3'd4;
            default:                                          r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] swap_by_lg(input logic [31:0] v, input logic [2:0] lg);
        logic [31:0] r;
        if (lg == 3'd4)
            r = {16'd0, v[7:0], v[15:8]};
        else
            r = {v[7:0], v[15:8], v[23:16], v[31:24]};
        return r;
    endfunction

    // ARGB8888 to buffer format (not yet masked to pixel width)
    function automatic logic [31:0] to_buffer(input logic [3:0] fmt, input logic [31:0] c);
        logic [9:0]  sum8;
        logic [9:0]  sum_sel;
        logic [19:0] prod;
        logic [31:0] r;
        sum8 = 10'(c[7:0]) + 10'(c[15:8]) + 10'(c[23:16]);
        if (fmt == FMT_GREY2)
            sum_sel = 10'(c[7:6]) + 10'(c[15:14]) + 10'(c[23:22]);
        else if (fmt == FMT_GREY4)
            sum_sel = 10'(c[7:4]) + 10'(c[15:12]) + 10'(c[23:20]);
        else
            sum_sel = sum8;
        prod = sum_sel * DIV3_RECIP;
        unique case (fmt)
            FMT_GREY1:                     r = {31'd0, sum8 > GREY1_LIMIT};
            FMT_GREY2, FMT_GREY4, FMT_GREY8: r = {23'd0, prod[19:11]};
            FMT_RGB332:   r = {24'd0, c[23:21], c[15:13], c[7:6]};
            FMT_RGB565:   r = {16'd0, c[23:19], c[15:10], c[7:3]};
            FMT_ARGB1111: r = {28'd0, c[31], c[23], c[15], c[7]};
            FMT_ARGB2222: r = {24'd0, c[31:30], c[23:22], c[15:14], c[7:6]};
            FMT_ARGB4444: r = {16'd0, c[31:28], c[23:20], c[15:12], c[7:4]};
            default:      r = c;
        endcase
        return r;
    endfunction

    // Buffer value to ARGB8888 for the formats that need no palette
    function automatic logic [31:0] to_argb(input logic [3:0] fmt, input logic [31:0] v);
        logic [31:0] r;
        unique case (fmt)
            FMT_GREY1: r = v[0] ? 32'hffffffff : 32'hff000000;
            FMT_GREY2: r = {8'hff, {12{v[1:0]}}};
            FMT_GREY4: r = {8'hff, {6{v[3:0]}}};
            FMT_GREY8: r = {8'hff, v[7:0], v[7:0], v[7:0]};
            FMT_RGB332:
                r = {8'hff, v[7:5], v[7:5], v[7:6], v[4:2], v[4:2], v[4:3], {4{v[1:0]}}};
            FMT_RGB565:
                r = {8'hff, v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
            FMT_ARGB1111: r = {{8{v[3]}}, {8{v[2]}}, {8{v[1]}}, {8{v[0]}}};
            FMT_ARGB2222:
                r = {{4{v[7:6]}}, {4{v[5:4]}}, {4{v[3:2]}}, {4{v[1:0]}}};
            FMT_ARGB4444:
                r = {v[15:12], v[15:12], v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/fpac_if.sv
interface fpac_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [16:0] index;
    logic [31:0] color;
    modport source (output valid, action, index, color, input ready);
    modport sink   (input valid, action, index, color, output ready);
endinterface

interface fpac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_value;
    logic [31:0] argb;
    logic        out_of_range;
    modport source (output valid, raw_value, argb, out_of_range, input ready);
    modport sink   (input valid, raw_value, argb, out_of_range, output ready);
endinterface

>>> hdl/fpac_front.sv
module fpac_front
    import fpac_pkg::*;
#(
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    fpac_in_if.sink   in_ch,
    input  cfg_t      cfg,
    input  logic      q_ready,
    output logic      q_push,
    output q_entry_t  q_data
);

    localparam int LW = 21;

    logic [2:0]  lg;
    logic [21:0] bitpos;
    logic [21:0] last_bit;
    logic [LW-1:0] last_byte;
    logic [31:0] mask;
    logic [31:0] conv;
    logic [31:0] stored;
    logic        rev;

    assign in_ch.ready = q_ready;
    assign q_push      = in_ch.valid && q_ready;

    always_comb
    begin
        lg        = fmt_lg(cfg.fmt);
        bitpos    = 22'(in_ch.index) << lg;
        last_bit  = bitpos + ((22'd1 << lg) - 22'd1);
        last_byte = LW'(last_bit[21:3]);
        mask      = (lg == 3'd5) ? 32'hffffffff : ((32'd1 << (6'd1 << lg)) - 32'd1);
        conv      = to_buffer(cfg.fmt, in_ch.color) & mask;
        rev       = cfg.swap && (lg >= 3'd4);
        stored    = rev ? swap_by_lg(conv, lg) : conv;

        q_data.action = in_ch.action;
        q_data.lg     = lg;
        q_data.mask   = mask;
        q_data.off    = bitpos[4:0];
        if (in_ch.action == ACT_PAL_WRITE)
        begin
            q_data.oor  = 18'(in_ch.index) >= 18'(PALETTE_ENTRIES);
            q_data.addr = ADDR_W'(in_ch.index);
            q_data.wval = in_ch.color;
            q_data.raw  = in_ch.color;
        end
        else
        begin
            q_data.oor  = (in_ch.action != ACT_NONE) && (last_byte >= LW'(FRAME_BYTES));
            q_data.addr = ADDR_W'(bitpos[21:5]);
            q_data.wval = stored << bitpos[4:0];
            q_data.raw  = conv;
        end
    end

endmodule

>>> hdl/fpac_queue.sv
module fpac_queue
    import fpac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     ready,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [PW:0]       cnt_reg, cnt_next;

    assign ready      = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (push)
            wptr_next = (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

endmodule

>>> hdl/fpac_back.sv
module fpac_back
    import fpac_pkg::*;
#(
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  q_entry_t  q_head,
    output logic      q_pop,
    fpac_out_if.source out_ch
);

    localparam int FRAME_WORDS = FRAME_BYTES / 4;
    localparam int FAW         = $clog2(FRAME_WORDS);
    localparam int PAW         = $clog2(PALETTE_ENTRIES);

    logic [31:0] frame_mem   [FRAME_WORDS];
    logic [31:0] palette_mem [PALETTE_ENTRIES];
    logic [31:0] frame_rd_reg;
    logic [31:0] pal_rd_reg;

    back_state_t state_reg, state_next;
    q_entry_t    cur_reg, cur_next;
    logic [31:0] raw_reg, raw_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_raw_reg, out_raw_next;
    logic [31:0] out_argb_reg, out_argb_next;
    logic        out_oor_reg, out_oor_next;

    logic            frame_we, pal_we;
    logic [FAW-1:0]  frame_raddr;
    logic [PAW-1:0]  pal_raddr;
    logic [31:0]     frame_wdata;
    logic [31:0]     extracted;
    logic            rev;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.raw_value    = out_raw_reg;
    assign out_ch.argb         = out_argb_reg;
    assign out_ch.out_of_range = out_oor_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        raw_next       = raw_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_raw_next   = out_raw_reg;
        out_argb_next  = out_argb_reg;
        out_oor_next   = out_oor_reg;
        q_pop          = 1'b0;
        frame_we       = 1'b0;
        pal_we         = 1'b0;
        frame_raddr    = q_head.addr[FAW-1:0];
        pal_raddr      = '0;
        rev            = cfg.swap && (cur_reg.lg >= 3'd4);
        extracted      = (frame_rd_reg >> cur_reg.off) & cur_reg.mask;
        frame_wdata    = (frame_rd_reg & ~(cur_reg.mask << cur_reg.off)) | cur_reg.wval;

        unique case (state_reg)
            B_IDLE:
            begin
                // start as soon as the result register is empty or being taken
                if (q_valid && (!out_valid_reg || out_ch.ready))
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    state_next = B_FRAME;
                end
            end
            B_FRAME:
            begin
                // raw value known now; palette lookup issued for the next cycle
                if (cur_reg.oor || cur_reg.action == ACT_NONE)
                    raw_next = '0;
                else if (cur_reg.action == ACT_READ)
                    raw_next = rev ? swap_by_lg(extracted, cur_reg.lg) : extracted;
                else
                    raw_next = cur_reg.raw;
                frame_we = (cur_reg.action == ACT_WRITE) && !cur_reg.oor;
                pal_we   = (cur_reg.action == ACT_PAL_WRITE) && !cur_reg.oor;
                if (raw_next < 32'(cfg.pal_count) && raw_next < 32'(PALETTE_ENTRIES))
                    pal_raddr = raw_next[PAW-1:0];
                state_next = B_PAL;
            end
            B_PAL:
            begin
                out_valid_next = 1'b1;
                out_raw_next   = raw_reg;
                out_oor_next   = cur_reg.oor;
                if (cur_reg.oor || cur_reg.action == ACT_NONE)
                    out_argb_next = '0;
                else if (cur_reg.action == ACT_PAL_WRITE)
                    out_argb_next = raw_reg;
                else if (cfg.fmt <= FMT_PAL16)
                    out_argb_next = pal_rd_reg;
                else
                    out_argb_next = to_argb(cfg.fmt, raw_reg);
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        raw_reg      <= raw_next;
        out_raw_reg  <= out_raw_next;
        out_argb_reg <= out_argb_next;
        out_oor_reg  <= out_oor_next;
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
            frame_mem[cur_reg.addr[FAW-1:0]] <= frame_wdata;
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            palette_mem[cur_reg.addr[PAW-1:0]] <= cur_reg.wval;
        pal_rd_reg <= palette_mem[pal_raddr];
    end

endmodule

>>> hdl/framebuffer_pixel_access_convert_core.sv
// Packed framebuffer with pixel format conversion.
// in_ch (valid/ready) carries one access: read pixel, write pixel or write a palette
// entry. out_ch (valid/ready) returns one transfer per access: raw buffer value, its
// ARGB8888 expansion and an out-of-range flag. Nothing is written for a flagged access.
// The front classifies each access (address, bit offset, conversion to buffer format)
// and pushes it into a two-entry queue; the back runs a word-wide read-modify-write on
// the frame memory, then a palette read, then loads the output register.
// An access passes through the queue, then the back's frame, palette and result steps.
// The back takes one access at a time through its three-step sequence (frame read,
// palette read, result); meanwhile the queue keeps accepting accesses until full.
// A receiver stall holds the result register; the back starts no new access until it is
// taken, and in_ch.ready falls once the queue holds two accesses.
// Config registers (APB, byte addresses 0/4/8): pixel_format, byte_swap, palette_count;
// write only while idle. Reset clears control state and sets format to ARGB8888;
// frame and palette contents stay undefined until written, with no clearing pass.
module framebuffer_pixel_access_convert_core
    import fpac_pkg::*;
#(
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    fpac_in_if.sink     in_ch,
    fpac_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t     cfg_reg, cfg_next;
    logic     q_push, q_ready, q_pop, q_valid;
    q_entry_t q_in, q_head;
    logic     cfg_wr;

    // Config port: no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FORMAT:    cfg_next.fmt       = pwdata[3:0];
                REG_SWAP:      cfg_next.swap      = pwdata[0];
                REG_PAL_COUNT: cfg_next.pal_count = pwdata[8:0];
                default:       cfg_next = cfg_reg;   // unmapped, ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FORMAT:    prdata = {28'd0, cfg_reg.fmt};
            REG_SWAP:      prdata = {31'd0, cfg_reg.swap};
            REG_PAL_COUNT: prdata = {23'd0, cfg_reg.pal_count};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt       <= FORMAT_RST;
            cfg_reg.swap      <= 1'b0;
            cfg_reg.pal_count <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Front: classify and convert
    fpac_front #(
        .FRAME_BYTES     (FRAME_BYTES),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .in_ch   (in_ch),
        .cfg     (cfg_reg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    // Decoupling queue
    fpac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Back: memory access and expansion
    fpac_back #(
        .FRAME_BYTES     (FRAME_BYTES),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

>>> hdl/fpac_checker.sv
module fpac_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_raw,
    input logic [31:0] out_argb,
    input logic        out_oor,
    input logic        pready
);

    // A stalled result transfer keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_raw) && $stable(out_argb)
            && $stable(out_oor))
        else $error("result changed while stalled");

    // A flagged access reports zero values
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_oor |-> out_raw == 32'd0 && out_argb == 32'd0)
        else $error("out-of-range result carries data");

    // No result while in reset
    a_rst: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind framebuffer_pixel_access_convert_core fpac_checker u_fpac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_raw   (out_ch.raw_value),
    .out_argb  (out_ch.argb),
    .out_oor   (out_ch.out_of_range),
    .pready    (pready)
);

>>> tb/sv/framebuffer_pixel_access_convert_core_tb.sv
`timescale 1ns / 1ps

module framebuffer_pixel_access_convert_core_tb;
    import fpac_pkg::*;

    localparam int STORE_BYTES = 16384;
    localparam int PAL_SIZE    = 256;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [1:0]  action;
        logic [16:0] index;
        logic [31:0] color;
    } access_t;

    typedef struct {
        logic [31:0] raw;
        logic [31:0] argb;
        logic        oor;
    } pixel_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpac_in_if  in_ch ();
    fpac_out_if out_ch ();

    framebuffer_pixel_access_convert_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block: store, palette and register settings
    logic [7:0]  frame_mem [0:STORE_BYTES-1];
    logic [31:0] pal_mem [0:PAL_SIZE-1];
    logic [3:0]  cur_fmt;
    logic        cur_swap;
    logic [8:0]  cur_count;

    // Stimulus-side bookkeeping: which pixel bits and palette entries hold data,
    // so that no read ever touches an unwritten location
    bit          gen_bits [0:STORE_BYTES*8-1];
    bit          pal_set [0:PAL_SIZE-1];
    logic [3:0]  gen_fmt;

    access_t       pending_q [$];
    pixel_result_t pixel_results_q [$];

    bit  in_took;
    int  accepted_cnt;
    int  results_cnt;
    int  fail_cnt;
    int  cycle_cnt;
    int  hold_left;
    bit  held;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int fmt_bits(input logic [3:0] f);
        case (f)
            FMT_PAL1, FMT_GREY1:                           return 1;
            FMT_PAL2, FMT_GREY2:                           return 2;
            FMT_PAL4, FMT_GREY4, FMT_ARGB1111:             return 4;
            FMT_PAL8, FMT_GREY8, FMT_RGB332, FMT_ARGB2222: return 8;
            FMT_PAL16, FMT_RGB565, FMT_ARGB4444:           return 16;
            default:                                       return 32;
        endcase
    endfunction

    // Sum of the three colour channels, each cut to its top 'keep' bits
    function automatic logic [31:0] chan_sum(input logic [31:0] c, input int keep);
        int drop;
        logic [31:0] m;
        drop = 8 - keep;
        m = (32'd1 << keep) - 32'd1;
        return ((c >> drop) & m) + ((c >> (8 + drop)) & m) + ((c >> (16 + drop)) & m);
    endfunction

    function automatic logic [31:0] encode_pixel(input logic [3:0] f, input logic [31:0] c);
        case (f)
            FMT_PAL1:     return c & 32'h1;
            FMT_PAL2:     return c & 32'h3;
            FMT_PAL4:     return c & 32'hf;
            FMT_PAL8:     return c & 32'hff;
            FMT_PAL16:    return c & 32'hffff;
            FMT_GREY1:    return (chan_sum(c, 8) > 32'd384) ? 32'd1 : 32'd0;
            FMT_GREY2:    return chan_sum(c, 2) / 3;
            FMT_GREY4:    return chan_sum(c, 4) / 3;
            FMT_GREY8:    return chan_sum(c, 8) / 3;
            FMT_RGB332:   return ((c >> 16) & 32'he0) | ((c >> 11) & 32'h1c) | ((c >> 6) & 32'h03);
            FMT_RGB565:
                return ((c >> 8) & 32'hf800) | ((c >> 5) & 32'h07e0) | ((c >> 3) & 32'h001f);
            FMT_ARGB1111:
                return ((c >> 28) & 32'h8) | ((c >> 21) & 32'h4) | ((c >> 14) & 32'h2)
                       | ((c >> 7) & 32'h1);
            FMT_ARGB2222:
                return ((c >> 24) & 32'hc0) | ((c >> 18) & 32'h30) | ((c >> 12) & 32'h0c)
                       | ((c >> 6) & 32'h03);
            FMT_ARGB4444:
                return ((c >> 16) & 32'hf000) | ((c >> 12) & 32'h0f00) | ((c >> 8) & 32'h00f0)
                       | ((c >> 4) & 32'h000f);
            default:      return c;
        endcase
    endfunction

    // Widen a k-bit channel to 8 bits by repeating it from the top down
    function automatic logic [7:0] widen_chan(input logic [31:0] v, input int k);
        logic [31:0] r;
        int pos;
        r = 0;
        pos = 8;
        while (pos > 0)
        begin
            pos -= k;
            if (pos >= 0)
                r |= v << pos;
            else
                r |= v >> (-pos);
        end
        return r[7:0];
    endfunction

    function automatic logic [31:0] expand_pixel(input logic [3:0] f, input logic [31:0] v);
        logic [31:0] lim;
        lim = (cur_count < PAL_SIZE) ? cur_count : PAL_SIZE;
        case (f)
            FMT_PAL1, FMT_PAL2, FMT_PAL4, FMT_PAL8, FMT_PAL16:
                return (v < lim) ? pal_mem[v[7:0]] : pal_mem[0];  // miss falls back to entry 0
            FMT_GREY1:    return v[0] ? 32'hffffffff : 32'hff000000;
            FMT_GREY2:    return 32'hff000000 | (v[1:0] * 32'h00555555);
            FMT_GREY4:    return 32'hff000000 | (v[3:0] * 32'h00111111);
            FMT_GREY8:    return 32'hff000000 | (v[7:0] * 32'h00010101);
            FMT_RGB332:
                return {8'hff, widen_chan(v[7:5], 3), widen_chan(v[4:2], 3), widen_chan(v[1:0], 2)};
            FMT_RGB565:
                return {8'hff, widen_chan(v[15:11], 5), widen_chan(v[10:5], 6),
                        widen_chan(v[4:0], 5)};
            FMT_ARGB1111:
                return {widen_chan(v[3], 1), widen_chan(v[2], 1), widen_chan(v[1], 1),
                        widen_chan(v[0], 1)};
            FMT_ARGB2222:
                return {widen_chan(v[7:6], 2), widen_chan(v[5:4], 2), widen_chan(v[3:2], 2),
                        widen_chan(v[1:0], 2)};
            FMT_ARGB4444:
                return {widen_chan(v[15:12], 4), widen_chan(v[11:8], 4), widen_chan(v[7:4], 4),
                        widen_chan(v[3:0], 4)};
            default:      return v;
        endcase
    endfunction

    function automatic logic [31:0] byte_rev(input logic [31:0] v, input int nb);
        logic [31:0] r;
        r = 0;
        for (int i = 0; i < nb; i++)
            r |= ((v >> (8 * i)) & 32'hff) << (8 * (nb - 1 - i));
        return r;
    endfunction

    // Work out the transfer an access produces and update the shadow state
    function automatic pixel_result_t predict_access(input access_t a);
        pixel_result_t res;
        int bits;
        int nb;
        longint bitpos;
        longint last;
        longint at;
        int sh;
        logic [31:0] mask;
        logic [31:0] stored;
        bit rev;
        res = '{32'd0, 32'd0, 1'b0};
        bits = fmt_bits(cur_fmt);
        if (a.action == ACT_PAL_WRITE)
        begin
            if (a.index < PAL_SIZE)
            begin
                pal_mem[a.index[7:0]] = a.color;
                res.raw = a.color;
                res.argb = a.color;
            end
            else
                res.oor = 1'b1;
        end
        else if (a.action == ACT_READ || a.action == ACT_WRITE)
        begin
            bitpos = longint'(a.index) * bits;
            last = (bitpos + bits - 1) >> 3;
            at = bitpos >> 3;
            if (last >= STORE_BYTES)
                res.oor = 1'b1;
            else if (bits < 8)
            begin
                sh = int'(bitpos & 7);
                mask = (32'd1 << bits) - 32'd1;
                if (a.action == ACT_WRITE)
                begin
                    res.raw = encode_pixel(cur_fmt, a.color) & mask;
                    frame_mem[at] = (frame_mem[at] & ~(mask[7:0] << sh)) | (res.raw[7:0] << sh);
                end
                else
                    res.raw = ({24'd0, frame_mem[at]} >> sh) & mask;
                res.argb = expand_pixel(cur_fmt, res.raw);
            end
            else
            begin
                nb = bits / 8;
                rev = cur_swap && nb >= 2;
                if (a.action == ACT_WRITE)
                begin
                    res.raw = encode_pixel(cur_fmt, a.color);
                    if (nb < 4)
                        res.raw &= (32'd1 << (8 * nb)) - 32'd1;
                    stored = rev ? byte_rev(res.raw, nb) : res.raw;
                    for (int i = 0; i < nb; i++)
                        frame_mem[at + i] = stored[8*i +: 8];
                end
                else
                begin
                    stored = 0;
                    for (int i = 0; i < nb; i++)
                        stored |= {24'd0, frame_mem[at + i]} << (8 * i);
                    res.raw = rev ? byte_rev(stored, nb) : stored;
                end
                res.argb = expand_pixel(cur_fmt, res.raw);
            end
        end
        return res;
    endfunction

    // Queue an access and note what it writes, for legality of later reads
    task automatic push_access(input logic [1:0] act, input logic [16:0] idx,
                               input logic [31:0] c);
        int b;
        longint bp;
        b = fmt_bits(gen_fmt);
        bp = longint'(idx) * b;
        if (act == ACT_WRITE && ((bp + b - 1) >> 3) < STORE_BYTES)
            for (int i = 0; i < b; i++)
                gen_bits[bp + i] = 1'b1;
        if (act == ACT_PAL_WRITE && idx < PAL_SIZE)
            pal_set[idx] = 1'b1;
        pending_q.push_back('{act, idx, c});
    endtask

    function automatic bit readable(input logic [16:0] idx);
        int b;
        longint bp;
        b = fmt_bits(gen_fmt);
        bp = longint'(idx) * b;
        if (((bp + b - 1) >> 3) >= STORE_BYTES)
            return 1'b1;   // flagged, touches nothing
        for (int i = 0; i < b; i++)
            if (!gen_bits[bp + i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Sender pause: everything offered, accepted and answered, then settle time
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_ch.valid || pixel_results_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One setting of the registers, palette filled as far as reads need it,
    // then a burst of random accesses clustered in a small pixel window
    task automatic run_phase(input logic [3:0] f, input logic sw, input logic [8:0] cnt,
                             input int n);
        int lim;
        int b;
        int max_idx;
        int base;
        int roll;
        logic [16:0] idx;
        wait_drained();
        apb_write(REG_FORMAT, {28'd0, f});
        apb_write(REG_SWAP, {31'd0, sw});
        apb_write(REG_PAL_COUNT, {23'd0, cnt});
        cur_fmt   = f;
        cur_swap  = sw;
        cur_count = cnt;
        gen_fmt   = f;
        lim = (cnt < PAL_SIZE) ? cnt : PAL_SIZE;
        for (int e = 0; e < lim; e++)
            if (!pal_set[e])
                push_access(ACT_PAL_WRITE, 17'(e), $urandom);
        b = fmt_bits(f);
        max_idx = (STORE_BYTES * 8) / b - 1;
        base = $urandom_range(0, max_idx - 31);
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            idx = 17'(base + $urandom_range(0, 31));
            if (roll < 4)
                push_access(ACT_NONE, 17'($urandom), $urandom);
            else if (roll < 8)
                push_access(ACT_PAL_WRITE,
                            $urandom_range(0, 1) ? 17'($urandom_range(0, PAL_SIZE - 1))
                                                 : 17'($urandom_range(PAL_SIZE, 131071)),
                            $urandom);
            else if (roll < 12 && max_idx < 131071)
                push_access($urandom_range(0, 1) ? ACT_READ : ACT_WRITE,
                            17'($urandom_range(max_idx + 1, 131071)), $urandom);
            else if (roll < 55 && readable(idx))
                push_access(ACT_READ, idx, $urandom);
            else
                push_access(ACT_WRITE, idx, $urandom);
        end
    endtask

    // Driver: changes the request on the falling edge only
    always @(negedge clk)
    begin : drive_in
        access_t nxt;
        bit calm;
        calm = accepted_cnt >= 500 && accepted_cnt < 700;
        if (rst_n && (!in_ch.valid || in_took))
        begin
            if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 34))
            begin
                nxt = pending_q.pop_front();
                in_ch.action <= nxt.action;
                in_ch.index  <= nxt.index;
                in_ch.color  <= nxt.color;
                in_ch.valid  <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Accepted request: predict its transfer
    always @(posedge clk)
    begin
        in_took = in_ch.valid && in_ch.ready;
        if (in_took)
        begin
            pixel_results_q.push_back(predict_access('{in_ch.action, in_ch.index, in_ch.color}));
            accepted_cnt++;
        end
    end

    // Receiver readiness, with one long hold-off so the queue backs up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (results_cnt >= 200 && !held)
            begin
                held = 1'b1;
                hold_left = 150;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= (results_cnt >= 500 && results_cnt < 700)
                                || $urandom_range(0, 99) >= 34;
        end
    end

    // Monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin : check_out
        pixel_result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            results_cnt++;
            if (pixel_results_q.size() == 0)
            begin
                $error("unexpected transfer: raw_value %h argb %h", out_ch.raw_value, out_ch.argb);
                fail_cnt++;
            end
            else
            begin
                want = pixel_results_q.pop_front();
                if (out_ch.raw_value !== want.raw)
                begin
                    $error("raw_value: expected %h, got %h", want.raw, out_ch.raw_value);
                    fail_cnt++;
                end
                if (out_ch.argb !== want.argb)
                begin
                    $error("argb: expected %h, got %h", want.argb, out_ch.argb);
                    fail_cnt++;
                end
                if (out_ch.out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %b, got %b", want.oor, out_ch.out_of_range);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [8:0] cnt;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_READ;
        in_ch.index  = '0;
        in_ch.color  = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
            frame_mem[i] = 8'd0;
        for (int i = 0; i < PAL_SIZE; i++)
            pal_mem[i] = 32'd0;
        cur_fmt   = FORMAT_RST;
        cur_swap  = 1'b0;
        cur_count = 9'd0;
        gen_fmt   = FORMAT_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: reset format ARGB8888, palette ends, flagged indices, action three
        push_access(ACT_PAL_WRITE, 17'd0, 32'hff123456);
        push_access(ACT_PAL_WRITE, 17'd255, 32'h00abcdef);
        push_access(ACT_PAL_WRITE, 17'd256, 32'hffffffff);
        push_access(ACT_PAL_WRITE, 17'h1ffff, 32'h12345678);
        push_access(ACT_WRITE, 17'd0, 32'hffffffff);
        push_access(ACT_WRITE, 17'd4095, 32'h00000000);
        push_access(ACT_READ, 17'd0, 32'd0);
        push_access(ACT_READ, 17'd4095, 32'hffffffff);
        push_access(ACT_WRITE, 17'd4096, 32'hdeadbeef);
        push_access(ACT_READ, 17'h1ffff, 32'd0);
        push_access(ACT_NONE, 17'h1ffff, 32'hffffffff);
        push_access(ACT_WRITE, 17'd1, 32'h80808080);
        push_access(ACT_READ, 17'd1, 32'd0);
        push_access(ACT_WRITE, 17'd2, 32'h7f7f7f7f);
        push_access(ACT_READ, 17'd2, 32'd0);

        // Every format, both swap settings, palette count at its extremes and between
        for (int f = 0; f < 16; f++)
            for (int sw = 0; sw < 2; sw++)
            begin
                case ((2 * f + sw) % 4)
                    0:       cnt = 9'd0;
                    1:       cnt = 9'd256;
                    2:       cnt = 9'($urandom_range(1, 16));
                    default: cnt = 9'($urandom_range(257, 511));
                endcase
                run_phase(4'(f), sw[0], cnt, 34);
            end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
